>>> rtl/mpsi_pkg.sv
// Package for the multichannel power statistics integrator.
// Holds the widths, the record types passed between front, queues and back,
// and the register map constants. No dependencies.
package mpsi_pkg;

  localparam int NUM_CH    = 5;
  localparam int VAL_W     = 20;
  localparam int TIME_W    = 48;
  localparam int CNT_W     = 32;
  localparam int CH_W      = 3;
  localparam int EN_W      = 5;
  localparam int INTEG_W   = 64;
  localparam int SUM_W     = VAL_W + 1;
  localparam int HALF_W    = TIME_W / 2;
  localparam int PROD_W    = SUM_W + HALF_W;
  localparam int FULL_W    = PROD_W + HALF_W;
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Register map: one register, indexed by paddr[2]
  localparam int          PADDR_W            = 3;
  localparam logic        REG_CHANNEL_ENABLE = 1'b0;
  localparam logic [EN_W-1:0] ENABLE_RESET   = EN_W'(1);

  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [INTEG_W-1:0] integ_t;

  // One accepted sample, ready for per-channel processing
  typedef struct packed {
    time_t                 delta;
    time_t                 elapsed;
    count_t                count;
    logic [NUM_CH-1:0]     mask;
    value_t [NUM_CH-1:0]   cur;
    sum_t   [NUM_CH-1:0]   sum;
  } sample_rec_t;

  // One result item
  typedef struct packed {
    chan_t  channel;
    count_t sample_total;
    value_t channel_min;
    value_t channel_max;
    integ_t integral_doubled;
    time_t  elapsed_us;
    logic   last;
  } result_t;

endpackage

>>> rtl/multichannel_power_stats_integrator.sv
// Multichannel power statistics integrator, top level.
// A sample is taken into the input queue; the result of each enabled channel then passes
// through product, combine and accumulate into the result queue, in channel order.
// Throughput: one result per cycle from the shared multiply-accumulate pipeline while
// the result queue has room for it.
// Reset (rst, synchronous): clears counters, time base, statistics and queues;
// channel_enable returns to power only.
module multichannel_power_stats_integrator (
  input  logic                                clk,
  input  logic                                rst,
  // Sample input
  input  logic                                push,
  output logic                                full,
  input  logic [47:0]                         timestamp_us,
  input  logic [19:0]                         power_mw,
  input  logic [15:0]                         sm_clock_mhz,
  input  logic [15:0]                         mem_clock_mhz,
  input  logic [6:0]                          mem_util_pct,
  input  logic [6:0]                          gpu_util_pct,
  // Results
  output logic                                empty,
  input  logic                                pop,
  output logic [2:0]                          channel,
  output logic [31:0]                         sample_total,
  output logic [19:0]                         channel_min,
  output logic [19:0]                         channel_max,
  output logic [63:0]                         integral_doubled,
  output logic [47:0]                         elapsed_us,
  output logic                                last,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpsi_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  import mpsi_pkg::*;

  logic [EN_W-1:0]     channel_enable;
  logic                accept;
  value_t [NUM_CH-1:0] readings;
  logic                rec_valid;
  sample_rec_t         rec;
  sample_rec_t         head;
  logic                head_empty;
  logic                head_pop;
  logic [$clog2(IN_DEPTH+1)-1:0] in_count;
  logic                res_push;
  result_t             res;
  result_t             out_head;
  logic [OUT_CNT_W-1:0] out_count;

  // Configuration register write and readback
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= ENABLE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_ENABLE) begin
      channel_enable <= pwdata[EN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CHANNEL_ENABLE) ? 32'(channel_enable) : '0;

  // Gather the readings into channel order
  assign accept      = push && !full;
  assign readings[0] = power_mw;
  assign readings[1] = VAL_W'(sm_clock_mhz);
  assign readings[2] = VAL_W'(mem_clock_mhz);
  assign readings[3] = VAL_W'(mem_util_pct);
  assign readings[4] = VAL_W'(gpu_util_pct);

  mpsi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .timestamp_us (timestamp_us),
    .readings     (readings),
    .enable       (channel_enable),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  mpsi_queue #(
    .WIDTH ($bits(sample_rec_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_valid),
    .wdata (rec),
    .pop   (head_pop),
    .rdata (head),
    .full  (full),
    .empty (head_empty),
    .count (in_count)
  );

  mpsi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!head_empty && (in_count != '0)),
    .head       (head),
    .head_pop   (head_pop),
    .out_count  (out_count),
    .res_push   (res_push),
    .res        (res)
  );

  // Space is reserved ahead of issue, so the full flag is not needed here
  mpsi_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (out_head),
    .full  (),
    .empty (empty),
    .count (out_count)
  );

  // Drive the result ports from the oldest queued result
  assign channel          = out_head.channel;
  assign sample_total     = out_head.sample_total;
  assign channel_min      = out_head.channel_min;
  assign channel_max      = out_head.channel_max;
  assign integral_doubled = out_head.integral_doubled;
  assign elapsed_us       = out_head.elapsed_us;
  assign last             = out_head.last;

endmodule

>>> rtl/mpsi_queue.sv
// Small register-based FIFO used between front and back and on the result side.
// Standalone; width and depth come from parameters.
module mpsi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];

  // Store incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/mpsi_front.sv
// Front end: takes each sample, keeps the time base, sample count and previous
// readings, and builds one sample record for the back end. Uses mpsi_pkg.
module mpsi_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  mpsi_pkg::time_t                timestamp_us,
  input  mpsi_pkg::value_t [mpsi_pkg::NUM_CH-1:0] readings,
  input  logic [mpsi_pkg::EN_W-1:0]      enable,
  output logic                           rec_valid,
  output mpsi_pkg::sample_rec_t          rec
);

  import mpsi_pkg::*;

  logic   first_pending;
  time_t  start_time;
  time_t  previous_time;
  time_t  elapsed_time;
  count_t sample_counter;
  value_t previous_reading [NUM_CH];

  time_t  delta_c;
  time_t  elapsed_c;
  count_t counter_next;

  // Clamp time differences at zero when the timestamp runs backwards
  always_comb begin
    delta_c   = (timestamp_us >= previous_time) ? timestamp_us - previous_time : '0;
    elapsed_c = (timestamp_us >= start_time) ? timestamp_us - start_time : '0;
    if (first_pending) begin
      delta_c   = '0;
      elapsed_c = elapsed_time;
    end
    counter_next = (sample_counter == '1) ? sample_counter : sample_counter + CNT_W'(1);
  end

  // Build the record handed to the back end
  always_comb begin
    rec.delta   = delta_c;
    rec.elapsed = elapsed_c;
    rec.count   = counter_next;
    rec.mask    = NUM_CH'(enable);
    for (int c = 0; c < NUM_CH; c++) begin
      rec.cur[c] = readings[c];
      rec.sum[c] = SUM_W'(previous_reading[c]) + SUM_W'(readings[c]);
    end
  end

  // Drop samples with an empty mask after updating the state
  assign rec_valid = accept && (enable != '0);

  // Update sample state on every accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending  <= 1'b1;
      start_time     <= '0;
      previous_time  <= '0;
      elapsed_time   <= '0;
      sample_counter <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        previous_reading[c] <= '0;
      end
    end else if (accept) begin
      first_pending  <= 1'b0;
      if (first_pending) begin
        start_time <= timestamp_us;
      end
      previous_time  <= timestamp_us;
      elapsed_time   <= elapsed_c;
      sample_counter <= counter_next;
      for (int c = 0; c < NUM_CH; c++) begin
        previous_reading[c] <= readings[c];
      end
    end
  end

endmodule

>>> rtl/mpsi_back.sv
// Back end: walks the enabled channels of the head sample record, one per
// cycle if room, via a multiply/combine/accumulate pipeline. Uses mpsi_pkg.
module mpsi_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  mpsi_pkg::sample_rec_t             head,
  output logic                              head_pop,
  input  logic [mpsi_pkg::OUT_CNT_W-1:0]    out_count,
  output logic                              res_push,
  output mpsi_pkg::result_t                 res
);

  import mpsi_pkg::*;

  localparam int CRED_W = OUT_CNT_W + 1;

  typedef struct packed {
    chan_t  ch;
    value_t cur;
    logic   last;
    count_t count;
    time_t  elapsed;
  } tag_t;

  // Channel walk
  logic              active;
  logic [NUM_CH-1:0] pend;
  logic [NUM_CH-1:0] work;
  logic [NUM_CH-1:0] rest;
  chan_t             sel_ch;
  logic              found;
  logic              room;
  logic              issue;
  sum_t              sum_sel;
  logic [PROD_W-1:0] plo_c;
  logic [PROD_W-1:0] phi_c;

  // Pipeline registers
  logic              a_valid;
  tag_t              a_tag;
  logic [PROD_W-1:0] a_plo;
  logic [PROD_W-1:0] a_phi;
  logic              b_valid;
  tag_t              b_tag;
  integ_t            b_prod;
  logic [FULL_W-1:0] full_prod;

  // Per-channel statistics
  value_t min_store   [NUM_CH];
  value_t max_store   [NUM_CH];
  integ_t integ_store [NUM_CH];
  logic [INTEG_W:0] integ_sum;
  integ_t integ_next;
  value_t min_next;
  value_t max_next;

  // Pick the lowest pending channel and check for result space
  always_comb begin
    work   = active ? pend : head.mask;
    sel_ch = '0;
    found  = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (work[i] && !found) begin
        sel_ch = CH_W'(i);
        found  = 1'b1;
      end
    end
    rest     = work & ~(NUM_CH'(1) << sel_ch);
    room     = (CRED_W'(out_count) + CRED_W'(a_valid) + CRED_W'(b_valid))
               < CRED_W'(OUT_DEPTH);
    issue    = head_valid && found && room;
    head_pop = issue && (rest == '0);
    sum_sel  = head.sum[sel_ch];
    plo_c    = PROD_W'(sum_sel) * PROD_W'(head.delta[HALF_W-1:0]);
    phi_c    = PROD_W'(sum_sel) * PROD_W'(head.delta[TIME_W-1:HALF_W]);
  end

  // Hold the walk position across the channels of one record
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= '0;
    end else if (issue) begin
      active <= (rest != '0);
      pend   <= rest;
    end
  end

  // Stage A: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_tag.ch      <= sel_ch;
      a_tag.cur     <= head.cur[sel_ch];
      a_tag.last    <= (rest == '0);
      a_tag.count   <= head.count;
      a_tag.elapsed <= head.elapsed;
      a_plo         <= plo_c;
      a_phi         <= phi_c;
    end
  end

  // Stage B: combine halves and saturate the product to 64 bits
  assign full_prod = {a_phi, HALF_W'(0)} + FULL_W'(a_plo);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_tag  <= a_tag;
      b_prod <= (full_prod[FULL_W-1:INTEG_W] != '0) ? '1 : full_prod[INTEG_W-1:0];
    end
  end

  // Stage C: accumulate with saturation and update extremes
  always_comb begin
    integ_sum  = {1'b0, integ_store[b_tag.ch]} + {1'b0, b_prod};
    integ_next = integ_sum[INTEG_W] ? '1 : integ_sum[INTEG_W-1:0];
    min_next   = (b_tag.cur < min_store[b_tag.ch]) ? b_tag.cur : min_store[b_tag.ch];
    max_next   = (b_tag.cur > max_store[b_tag.ch]) ? b_tag.cur : max_store[b_tag.ch];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        min_store[c]   <= '1;
        max_store[c]   <= '0;
        integ_store[c] <= '0;
      end
    end else if (b_valid) begin
      min_store[b_tag.ch]   <= min_next;
      max_store[b_tag.ch]   <= max_next;
      integ_store[b_tag.ch] <= integ_next;
    end
  end

  // Hand the result to the output queue
  always_comb begin
    res_push             = b_valid;
    res.channel          = b_tag.ch;
    res.sample_total     = b_tag.count;
    res.channel_min      = min_next;
    res.channel_max      = max_next;
    res.integral_doubled = integ_next;
    res.elapsed_us       = b_tag.elapsed;
    res.last             = b_tag.last;
  end

endmodule
